>>> src/heard_station_mru_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Heard-station MRU table assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HEARD_STATION_MRU_TABLE_UNIT_MACROS_SVH
`define HEARD_STATION_MRU_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define HSMT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heard station table: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heard station table: next-cycle check failed");

`else

`define HSMT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HSMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/hsmt_pkg.sv
// ----------------------------------------------------------------------------
// Heard-station MRU table package
// Beat types, stored entry layout and constants of the heard-station table.
// ----------------------------------------------------------------------------
package hsmt_pkg;

    localparam int unsigned CALL_W    = 56;
    localparam int unsigned MODE_W    = 8;
    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LOC_W     = 48;
    localparam int unsigned RIDX_W    = 5;
    localparam int unsigned SLOT_W    = 5;

    localparam int unsigned TABLE_ENTRIES_DEF = 32;

    // Mode character of packet data (space).
    localparam logic [MODE_W-1:0] PACKET_MODE      = 8'd32;
    // Offset from dial to centre frequency.
    localparam logic [FREQ_W-1:0] CENTRE_OFFSET_HZ = 32'd1500;

    // Request type codes.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [CALL_W-1:0] callsign;
        logic [MODE_W-1:0] mode_char;
        logic [FREQ_W-1:0] dial_freq_hz;
        logic [TIME_W-1:0] time_stamp;
        logic [LOC_W-1:0]  locator;
        logic [RIDX_W-1:0] read_index;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_found;
        logic              evicted;
        logic              report;
        logic              entry_valid;
        logic [CALL_W-1:0] entry_call;
        logic [MODE_W-1:0] entry_mode;
        logic [FREQ_W-1:0] entry_freq;
        logic [TIME_W-1:0] entry_time;
        logic [LOC_W-1:0]  entry_locator;
    } rsp_t;

    // One stored table entry.
    typedef struct packed {
        logic [CALL_W-1:0] call;
        logic [MODE_W-1:0] mode;
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] tstamp;
        logic [LOC_W-1:0]  locator;
    } entry_t;

endpackage

>>> src/heard_station_mru_table_unit.sv
// ----------------------------------------------------------------------------
// Heard-station MRU table
// Most-recently-heard station list kept in one memory, updated by move to front.
// ----------------------------------------------------------------------------
// An update walks the table from slot 0 one slot per cycle through a single
// memory with a registered read: each cycle it writes the entry carried from
// the slot above into the current slot and picks up the old contents, so the
// new station lands in slot 0 and the rest move down until the first matching
// or empty slot (or the last slot) is dropped. The next request is accepted
// as soon as the result has moved to the output register. Reset clears a
// per-slot valid bit, so the table is usable right after reset with no
// clearing pass.
`include "heard_station_mru_table_unit_macros.svh"

module heard_station_mru_table_unit #(
    parameter int unsigned TABLE_ENTRIES = hsmt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hsmt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output hsmt_pkg::rsp_t rsp
);
    import hsmt_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // Control state.
    logic [1:0]               state_reg;
    logic [AW-1:0]            idx_reg;
    logic [TABLE_ENTRIES-1:0] vld_reg;
    logic                     rsp_valid_reg;

    // Request key and carried entry.
    logic [CALL_W-1:0] key_call_reg;
    logic [MODE_W-1:0] key_mode_reg;
    logic [FREQ_W-1:0] key_freq_reg;
    logic              key_packet_reg;
    logic              range_reg;
    entry_t            carry_reg;
    rsp_t              res_reg;
    rsp_t              rsp_reg;

    // Memory and its read port.
    entry_t  mem [TABLE_ENTRIES];
    entry_t  rd_data_reg;
    logic    rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic    mem_we;

    // Incoming beat decode.
    logic              req_fire;
    logic              in_packet;
    logic [FREQ_W:0]   freq_sum;
    logic [FREQ_W-1:0] in_freq;
    logic              in_range;

    // Scan decisions.
    logic slot_used;
    logic slot_match;
    logic scan_stop;
    logic out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Center frequency with saturation; packet entries and unknown dial store zero.
    always_comb
    begin
        in_packet = (req.mode_char == PACKET_MODE);
        freq_sum  = {1'b0, req.dial_freq_hz} + {1'b0, CENTRE_OFFSET_HZ};
        if (in_packet || (req.dial_freq_hz == '0))
        begin
            in_freq = '0;
        end
        else if (freq_sum[FREQ_W])
        begin
            in_freq = '1;
        end
        else
        begin
            in_freq = freq_sum[FREQ_W-1:0];
        end
        in_range = (32'(req.read_index) < 32'(TABLE_ENTRIES));
    end

    // Read address: request slot on accept, next slot while scanning.
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr = idx_reg + 1'b1;
        end
        else if (req.req_type == REQ_READ)
        begin
            rd_addr = AW'(req.read_index);
        end
        else
        begin
            rd_addr = '0;
        end
        mem_we = (state_reg == ST_SCAN);
    end

    // Match and stop decision on the slot whose data has just arrived.
    always_comb
    begin
        slot_used  = rd_vld_reg && (rd_data_reg.call[CALL_W-1 -: 8] != '0);
        slot_match = slot_used && (rd_data_reg.call == key_call_reg) &&
                     (rd_data_reg.mode == key_mode_reg) &&
                     (key_packet_reg || (rd_data_reg.freq == key_freq_reg));
        scan_stop  = !slot_used || slot_match || (idx_reg == LAST_SLOT);
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= carry_reg;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    // Sequencer, valid bits and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // The output beat is raised on hand-off and dropped once taken.
            if ((state_reg == ST_HOLD) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (req.req_type == REQ_READ) ? ST_READ : ST_SCAN;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_HOLD;
                end
                ST_SCAN:
                begin
                    vld_reg[idx_reg] <= 1'b1;
                    if (scan_stop)
                    begin
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request key, carried entry and result payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            key_call_reg   <= req.callsign;
            key_mode_reg   <= req.mode_char;
            key_freq_reg   <= in_freq;
            key_packet_reg <= in_packet;
            range_reg      <= in_range;
            carry_reg      <= '{call:    req.callsign,
                                mode:    req.mode_char,
                                freq:    in_freq,
                                tstamp:  req.time_stamp,
                                locator: in_packet ? '0 : req.locator};
        end
        if (state_reg == ST_READ)
        begin
            if (range_reg && rd_vld_reg)
            begin
                res_reg <= '{hit:           1'b0,
                             slot_found:    '0,
                             evicted:       1'b0,
                             report:        1'b0,
                             entry_valid:   (rd_data_reg.call[CALL_W-1 -: 8] != '0),
                             entry_call:    rd_data_reg.call,
                             entry_mode:    rd_data_reg.mode,
                             entry_freq:    rd_data_reg.freq,
                             entry_time:    rd_data_reg.tstamp,
                             entry_locator: rd_data_reg.locator};
            end
            else
            begin
                res_reg <= '0;
            end
        end
        if (state_reg == ST_SCAN)
        begin
            carry_reg <= rd_data_reg;
            if (scan_stop)
            begin
                res_reg <= '{hit:           slot_match,
                             slot_found:    SLOT_W'(idx_reg),
                             evicted:       slot_used && !slot_match,
                             report:        !key_packet_reg,
                             entry_valid:   1'b0,
                             entry_call:    '0,
                             entry_mode:    '0,
                             entry_freq:    '0,
                             entry_time:    '0,
                             entry_locator: '0};
            end
        end
        if ((state_reg == ST_HOLD) && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    // An eviction only happens when the walk reached the last slot.
    `HSMT_ASSERT_IMPLIES(a_evict_last, clk, rst_n,
        (state_reg == ST_SCAN) && scan_stop && slot_used && !slot_match,
        idx_reg == LAST_SLOT)
    // A finished result never reports both a hit and an eviction.
    `HSMT_ASSERT_IMPLIES(a_hit_or_evict, clk, rst_n,
        state_reg == ST_HOLD, !(res_reg.hit && res_reg.evicted))
    // An accepted update starts the walk at slot 0.
    `HSMT_ASSERT_NEXT(a_update_scan, clk, rst_n,
        req_fire && (req.req_type == REQ_UPDATE),
        (state_reg == ST_SCAN) && (idx_reg == '0))
    // A new result is presented only out of the hand-off state.
    `HSMT_ASSERT_IMPLIES(a_rsp_from_hold, clk, rst_n,
        $rose(rsp_valid_reg), $past(state_reg) == ST_HOLD)
    // Slot 0 holds an entry once any update walk has started.
    `HSMT_ASSERT_NEXT(a_front_valid, clk, rst_n,
        state_reg == ST_SCAN, vld_reg[0])

endmodule

>>> tb/heard_station_mru_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heard-station MRU table testbench
// Drives update and read beats into the table, keeps its own move-to-front
// copy of the station list, and checks every reply beat field by field.
// ----------------------------------------------------------------------------
module heard_station_mru_table_unit_test;

    import hsmt_pkg::*;

    localparam int unsigned TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int unsigned RANDOM_BEATS   = 1625;
    localparam int unsigned HOLD_AT_REPLY  = 300;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PRINT_LIMIT    = 100;

    // Non-packet mode characters and dial frequencies used by the stimulus.
    localparam logic [MODE_W-1:0] MODE_CHAR_U = 8'h55;
    localparam logic [MODE_W-1:0] MODE_CHAR_A = 8'h41;
    localparam logic [MODE_W-1:0] MODE_CHAR_F = 8'h46;
    localparam logic [FREQ_W-1:0] DIAL_40M    = 32'd7074000;
    localparam logic [FREQ_W-1:0] DIAL_20M    = 32'd14074000;
    localparam logic [FREQ_W-1:0] DIAL_TOP    = 32'hFFFF_FFFF;
    // Highest dial that still lands exactly on the top after the offset.
    localparam logic [FREQ_W-1:0] DIAL_EDGE   = 32'hFFFF_FFFF - 32'd1500;

    localparam logic [CALL_W-1:0] CALL_A = 56'h4B_31_41_42_43_20_20;
    localparam logic [CALL_W-1:0] CALL_B = 56'h57_32_58_59_5A_20_20;
    localparam logic [CALL_W-1:0] CALL_C = 56'h44_4C_33_51_52_53_20;
    localparam logic [CALL_W-1:0] CALL_D = 56'h56_4B_34_54_55_56_20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b1;
    rsp_t rsp;

    req_t        request_backlog [$];
    rsp_t        due_replies [$];
    entry_t      mru_table [TABLE_ENTRIES];
    logic [CALL_W-1:0] hot_calls [8];
    logic [CALL_W-1:0] wide_calls [64];

    int unsigned requests_taken = 0;
    int unsigned replies_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap       = 0;
    int unsigned take_gap       = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    heard_station_mru_table_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // Idle length between beats: mostly none or short, now and then long.
    // Every fourth stretch of 150 requests runs with no idling at all.
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ((requests_taken / 150) % 4 == 3)
            return 0;
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Applies one request to the local station list and returns its reply.
    function automatic rsp_t mru_apply_request(req_t r);
        rsp_t              reply;
        logic              packet;
        logic [FREQ_W-1:0] centre;
        logic [31:0]       slot;
        logic              found;
        logic              hit;
        int                s;
        reply = '0;
        if (r.req_type == REQ_READ) begin
            if (r.read_index < TABLE_ENTRIES) begin
                reply.entry_valid   = (mru_table[r.read_index].call[CALL_W-1 -: 8] != 8'h00);
                reply.entry_call    = mru_table[r.read_index].call;
                reply.entry_mode    = mru_table[r.read_index].mode;
                reply.entry_freq    = mru_table[r.read_index].freq;
                reply.entry_time    = mru_table[r.read_index].tstamp;
                reply.entry_locator = mru_table[r.read_index].locator;
            end
            return reply;
        end

        packet = (r.mode_char == PACKET_MODE);
        centre = '0;
        if (!packet && r.dial_freq_hz != '0) begin
            if (r.dial_freq_hz > 32'hFFFF_FFFF - CENTRE_OFFSET_HZ)
                centre = 32'hFFFF_FFFF;
            else
                centre = r.dial_freq_hz + CENTRE_OFFSET_HZ;
        end

        // First empty or matching slot wins; otherwise the last one goes.
        slot  = TABLE_ENTRIES - 1;
        found = 1'b0;
        hit   = 1'b0;
        for (s = 0; s < TABLE_ENTRIES && !found; s++) begin
            if (mru_table[s].call[CALL_W-1 -: 8] == 8'h00) begin
                found = 1'b1;
                slot  = s;
            end else if (mru_table[s].call == r.callsign && mru_table[s].mode == r.mode_char &&
                         (packet || mru_table[s].freq == centre)) begin
                found = 1'b1;
                hit   = 1'b1;
                slot  = s;
            end
        end

        // Move everything above the chosen slot down and put the station in front.
        for (s = slot; s > 0; s--)
            mru_table[s] = mru_table[s - 1];
        mru_table[0].call    = r.callsign;
        mru_table[0].mode    = r.mode_char;
        mru_table[0].freq    = packet ? '0 : centre;
        mru_table[0].tstamp  = r.time_stamp;
        mru_table[0].locator = packet ? '0 : r.locator;

        reply.hit        = hit;
        reply.slot_found = slot[SLOT_W-1:0];
        reply.evicted    = !found;
        reply.report     = !packet;
        return reply;
    endfunction

    task automatic push_update(logic [CALL_W-1:0] call, logic [MODE_W-1:0] mode,
                               logic [FREQ_W-1:0] dial, logic [TIME_W-1:0] tstamp,
                               logic [LOC_W-1:0] loc);
        req_t r;
        r.req_type     = REQ_UPDATE;
        r.callsign     = call;
        r.mode_char    = mode;
        r.dial_freq_hz = dial;
        r.time_stamp   = tstamp;
        r.locator      = loc;
        r.read_index   = 5'($urandom);
        request_backlog.push_back(r);
    endtask

    task automatic push_read(logic [RIDX_W-1:0] idx);
        req_t        r;
        logic [63:0] w;
        w              = random_word64();
        r.req_type     = REQ_READ;
        r.callsign     = w[CALL_W-1:0];
        r.mode_char    = 8'($urandom);
        r.dial_freq_hz = $urandom;
        r.time_stamp   = $urandom;
        w              = random_word64();
        r.locator      = w[LOC_W-1:0];
        r.read_index   = idx;
        request_backlog.push_back(r);
    endtask

    // Random request: reads, noise, blank callsigns, and mostly well-formed
    // updates drawn from a small hot set (hits) or a wide set (fills, evictions).
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        logic [63:0] w;
        w              = random_word64();
        r.req_type     = REQ_UPDATE;
        r.callsign     = w[CALL_W-1:0];
        r.mode_char    = 8'($urandom);
        r.dial_freq_hz = $urandom;
        r.time_stamp   = $urandom;
        w              = random_word64();
        r.locator      = w[LOC_W-1:0];
        r.read_index   = 5'($urandom);
        pick           = $urandom_range(0, 99);
        // Picks 31 to 38 keep every field random as noise updates.
        if (pick < 28) begin
            r.req_type = REQ_READ;
        end else if (pick < 31) begin
            r.callsign[CALL_W-1 -: 8] = 8'h00;
        end else if (pick >= 39) begin
            if ($urandom_range(0, 1) == 1) begin
                r.callsign     = hot_calls[$urandom_range(0, 7)];
                r.mode_char    = ($urandom_range(0, 1) == 1) ? PACKET_MODE : MODE_CHAR_U;
                r.dial_freq_hz = ($urandom_range(0, 1) == 1) ? DIAL_40M : DIAL_20M;
            end else begin
                r.callsign = wide_calls[$urandom_range(0, 63)];
                case ($urandom_range(0, 3))
                    0: r.mode_char = PACKET_MODE;
                    1: r.mode_char = MODE_CHAR_U;
                    2: r.mode_char = MODE_CHAR_A;
                    default: r.mode_char = MODE_CHAR_F;
                endcase
                case ($urandom_range(0, 5))
                    0: r.dial_freq_hz = '0;
                    1: r.dial_freq_hz = DIAL_40M;
                    2: r.dial_freq_hz = DIAL_20M;
                    3: r.dial_freq_hz = DIAL_TOP;
                    4: r.dial_freq_hz = DIAL_EDGE;
                    default: r.dial_freq_hz = $urandom;
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                r.locator = '0;
        end
        return r;
    endfunction

    task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t ns: reply %0d field %s expected %h, got %h",
                         $time, replies_seen, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_reply(rsp_t want, rsp_t got);
        note_field("hit", want.hit, got.hit);
        note_field("slot_found", want.slot_found, got.slot_found);
        note_field("evicted", want.evicted, got.evicted);
        note_field("report", want.report, got.report);
        note_field("entry_valid", want.entry_valid, got.entry_valid);
        note_field("entry_call", want.entry_call, got.entry_call);
        note_field("entry_mode", want.entry_mode, got.entry_mode);
        note_field("entry_freq", want.entry_freq, got.entry_freq);
        note_field("entry_time", want.entry_time, got.entry_time);
        note_field("entry_locator", want.entry_locator, got.entry_locator);
    endtask

    // Request driver: predicts each accepted beat and offers the next one.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && req_ready) begin
                due_replies.push_back(mru_apply_request(req));
                requests_taken++;
            end
            if (!req_valid || req_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    req       <= request_backlog.pop_front();
                    req_valid <= 1'b1;
                    send_gap  = idle_length();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks each accepted beat and paces rsp_ready, with one
    // long hold-off that lets the block back up into its request side.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                replies_seen++;
                if (due_replies.size() == 0) begin
                    if (mismatch_count < PRINT_LIMIT)
                        $display("%0t ns: reply %0d arrived with none expected, got %h",
                                 $time, replies_seen, rsp);
                    mismatch_count++;
                end else begin
                    check_reply(due_replies.pop_front(), rsp);
                end
                take_gap = idle_length();
                if (replies_seen == HOLD_AT_REPLY)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** heard_station_mru_table_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] w;
        int          n;
        for (n = 0; n < TABLE_ENTRIES; n++)
            mru_table[n] = '0;
        for (n = 0; n < 8; n++) begin
            w = random_word64();
            hot_calls[n] = {8'($urandom_range(1, 255)), w[47:0]};
        end
        for (n = 0; n < 64; n++) begin
            w = random_word64();
            wide_calls[n] = {8'($urandom_range(1, 255)), w[47:0]};
        end

        // Directed part: empty reads, packet and non-packet matching,
        // unknown dial, saturation at the top, blank callsign, field extremes.
        push_read(5'd0);
        push_read(5'd31);
        push_update(CALL_A, PACKET_MODE, DIAL_20M, 32'd100, 48'h4A_4E_35_38_41_42);
        push_update(CALL_A, MODE_CHAR_U, DIAL_20M, 32'd101, 48'h4A_4E_35_38_41_42);
        push_update(CALL_A, MODE_CHAR_U, DIAL_20M, 32'd102, 48'h46_4E_33_31_50_51);
        push_update(CALL_B, MODE_CHAR_U, '0, 32'd103, '0);
        push_update(CALL_B, MODE_CHAR_U, '0, 32'd104, 48'h1);
        push_update(CALL_C, MODE_CHAR_A, DIAL_TOP, 32'd105, 48'h2);
        push_update(CALL_C, MODE_CHAR_A, DIAL_EDGE, 32'd106, 48'h3);
        push_update(CALL_C, MODE_CHAR_A, DIAL_EDGE - 32'd1, 32'd107, 48'h4);
        push_update(CALL_A, PACKET_MODE, DIAL_40M, 32'd108, 48'hFFFF);
        for (n = 0; n < 5; n++)
            push_read(5'(n));
        // A blank callsign is stored but reads as empty, and the next update
        // takes that slot without shifting.
        push_update({8'h00, 48'h12_34_56_78_9A_BC}, MODE_CHAR_F, DIAL_40M, 32'd109, 48'h5);
        push_read(5'd0);
        push_update(CALL_D, MODE_CHAR_F, DIAL_40M, 32'd110, 48'h6);
        push_update('1, 8'hFF, DIAL_TOP, 32'hFFFF_FFFF, '1);
        push_update(CALL_D, 8'h00, '0, '0, '0);
        push_read(5'd0);
        push_read(5'd1);
        push_read(5'd6);

        for (n = 0; n < RANDOM_BEATS; n++)
            request_backlog.push_back(random_request());

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** heard_station_mru_table_unit: PASSED **");
        else
            $display("** heard_station_mru_table_unit: FAILED **");
        $finish;
    end

endmodule

>>> heard_station_mru_table_unit.f
+incdir+src
src/hsmt_pkg.sv
src/heard_station_mru_table_unit.sv
tb/heard_station_mru_table_unit_test.sv
